[rtl/prq_pkg.sv]
package prq_pkg;

	localparam int TASK_SLOTS_DEF  = 16;
	localparam int PRIO_LEVELS_DEF = 8;

	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 3;
	localparam int PID_W    = 4;
	localparam int POLICY_W = 2;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 8;

	localparam logic [OPCODE_W-1:0] OP_PUSH_TAIL  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_POP        = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STS_BAD_ID   = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_PRIO = 3'd2;
	localparam logic [STATUS_W-1:0] STS_DUP      = 3'd3;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW = 3'd4;
	localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd5;

	localparam logic [POLICY_W-1:0] POL_RR    = 2'd1;
	localparam logic [POLICY_W-1:0] POL_RESET = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic commit;
	} prq_cmd_t;

	typedef struct packed {
		logic out_free;
	} prq_sts_t;

endpackage

[rtl/prq_ram.sv]
module prq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/prq_ctrl.sv]
module prq_ctrl import prq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  prq_sts_t sts,
	output prq_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
			end
			S_COMMIT: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/prq_datapath.sv]
module prq_datapath import prq_pkg::*; #(
	parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
	parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [POLICY_W-1:0] cfg_wdata,
	input  logic [IN_W-1:0]     s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,
	input  prq_cmd_t            cmd,
	output prq_sts_t            sts
);

	localparam int ID_W  = $clog2(TASK_SLOTS);
	localparam int LVL_W = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	logic [POLICY_W-1:0] policy_q;
	logic [OPCODE_W-1:0] op_q;
	logic [7:0]          tid_q;
	logic [7:0]          prio_q;

	logic [TASK_SLOTS-1:0]  queued_q;
	logic [PRIO_LEVELS-1:0] mask_q;
	logic [CNT_W-1:0]       level_cnt_q  [PRIO_LEVELS];
	logic [ID_W-1:0]        level_head_q [PRIO_LEVELS];
	logic [ID_W-1:0]        level_tail_q [PRIO_LEVELS];
	logic [CNT_W-1:0]       shared_cnt_q;
	logic [ID_W-1:0]        shared_head_q;
	logic [ID_W-1:0]        shared_tail_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [PID_W-1:0]    pid_q;
	logic                pvalid_q;

	logic                rr, is_push, is_pop, id_ok, prio_ok;
	logic [ID_W-1:0]     id_idx;
	logic [LVL_W-1:0]    prio_lvl, enc_lvl, sel_lvl;
	logic [CNT_W-1:0]    q_cnt, new_cnt;
	logic [ID_W-1:0]     q_head, q_tail, new_head, new_tail;
	logic                do_push, do_pop, upd;
	logic [STATUS_W-1:0] status_d;
	logic [PID_W-1:0]    pid_d;
	logic                ram_we;
	logic [ID_W-1:0]     ram_waddr, ram_wdata, ram_rdata;

	always_comb begin
		enc_lvl = '0;
		for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				enc_lvl = LVL_W'(i);
			end
		end
	end

	always_comb begin
		rr       = (policy_q == POL_RR);
		is_push  = (op_q == OP_PUSH_TAIL) || (op_q == OP_PUSH_FRONT);
		is_pop   = (op_q == OP_POP);
		id_ok    = (tid_q < 8'(TASK_SLOTS));
		prio_ok  = (prio_q < 8'(PRIO_LEVELS));
		id_idx   = tid_q[ID_W-1:0];
		prio_lvl = prio_q[LVL_W-1:0];
		sel_lvl  = is_pop ? enc_lvl : prio_lvl;
		if (rr) begin
			q_cnt  = shared_cnt_q;
			q_head = shared_head_q;
			q_tail = shared_tail_q;
		end else begin
			q_cnt  = level_cnt_q[sel_lvl];
			q_head = level_head_q[sel_lvl];
			q_tail = level_tail_q[sel_lvl];
		end

		status_d = STS_OK;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		if (is_push) begin
			priority if (!id_ok) begin
				status_d = STS_BAD_ID;
			end else if (!rr && !prio_ok) begin
				status_d = STS_BAD_PRIO;
			end else if (queued_q[id_idx]) begin
				status_d = STS_DUP;
			end else if (q_cnt >= CNT_W'(TASK_SLOTS)) begin
				status_d = STS_OVERFLOW;
			end else begin
				do_push = 1'b1;
			end
		end else if (is_pop) begin
			if ((!rr && mask_q == '0) || q_cnt == '0) begin
				status_d = STS_EMPTY;
			end else begin
				do_pop = 1'b1;
			end
		end
		pid_d = do_pop ? PID_W'(q_head) : '0;

		new_cnt   = do_push ? q_cnt + CNT_W'(1) : q_cnt - CNT_W'(1);
		new_head  = q_head;
		new_tail  = q_tail;
		ram_we    = 1'b0;
		ram_waddr = q_tail;
		ram_wdata = id_idx;
		if (do_push) begin
			if (op_q == OP_PUSH_FRONT) begin
				new_head = id_idx;
				if (q_cnt == '0) begin
					new_tail = id_idx;
				end else begin
					ram_we    = cmd.commit;
					ram_waddr = id_idx;
					ram_wdata = q_head;
				end
			end else begin
				new_tail = id_idx;
				if (q_cnt == '0) begin
					new_head = id_idx;
				end else begin
					ram_we = cmd.commit;
				end
			end
		end
		if (do_pop && new_cnt != '0) begin
			new_head = ram_rdata;
		end
		upd = cmd.commit && (do_push || do_pop);
	end

	prq_ram #(
		.WIDTH(ID_W),
		.DEPTH(TASK_SLOTS)
	) u_link (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(q_head),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= s_tdata[1:0];
			tid_q  <= s_tdata[9:2];
			prio_q <= s_tdata[17:10];
		end
		if (cmd.commit) begin
			status_q <= status_d;
			pid_q    <= pid_d;
			pvalid_q <= do_pop;
		end
		if (upd) begin
			if (rr) begin
				shared_head_q <= new_head;
				shared_tail_q <= new_tail;
			end else begin
				level_head_q[sel_lvl] <= new_head;
				level_tail_q[sel_lvl] <= new_tail;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= POL_RESET;
			queued_q     <= '0;
			mask_q       <= '0;
			shared_cnt_q <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < PRIO_LEVELS; i++) begin
				level_cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (upd) begin
				if (do_push) begin
					queued_q[id_idx] <= 1'b1;
				end else begin
					queued_q[q_head] <= 1'b0;
				end
				if (rr) begin
					shared_cnt_q <= new_cnt;
				end else begin
					level_cnt_q[sel_lvl] <= new_cnt;
					if (do_push) begin
						mask_q[sel_lvl] <= 1'b1;
					end else if (new_cnt == '0) begin
						mask_q[sel_lvl] <= 1'b0;
					end
				end
			end
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = {pvalid_q, pid_q, status_q};

endmodule

[rtl/priority_ready_queue.sv]
// Ready queue for a task scheduler: one linked FIFO per priority level plus
// one shared FIFO used when the policy register selects global round robin.
// Input channel s_*: one request item per handshake (push at tail, push at
// front, pop). Output channel m_*: exactly one result item per request, in
// request order (status, popped id, popped-valid flag).
// Configuration: cfg_we writes cfg_wdata into the policy register; write it
// only while no request is in flight.
// The result is registered in the update step, after the request's next-link
// read. A new request is accepted only once the last has passed its accept,
// next-link read and update steps, because of the registered read of the
// shared next-link memory that each request goes through before its update.
// A new request is accepted while the previous result still waits in the
// output register; when the receiver stalls, that request holds in its
// update step and the input closes until the output register frees.
// Reset (arst_n low) empties every queue, clears the queued flags and sets
// the policy to per-level priority; no clearing pass is needed.
module priority_ready_queue import prq_pkg::*; #(
	parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
	parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [POLICY_W-1:0] cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_W-1:0]     s_tdata,   // opcode[1:0], task_id[9:2], task_prio[17:10]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata    // status[2:0], popped_id[6:3], popped_valid[7]
);

	prq_cmd_t cmd;
	prq_sts_t sts;

	prq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	prq_datapath #(
		.TASK_SLOTS (TASK_SLOTS),
		.PRIO_LEVELS(PRIO_LEVELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
